### hdl/omni_wheel_velocity_mixer_macros.svh
// Assertion macros for the omni wheel velocity mixer.
// No dependencies.
`ifndef OMNI_WHEEL_VELOCITY_MIXER_MACROS_SVH
`define OMNI_WHEEL_VELOCITY_MIXER_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define OWM_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication
`define OWM_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

### hdl/owm_pkg.sv
// Package for the omni wheel velocity mixer: widths, CORDIC table, register codes.
// No dependencies.
`default_nettype none
package owm_pkg;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int ADDR_W = 6;
   localparam logic [34:0] CORDIC_GAIN = 35'sd652032874;

   typedef enum logic [2:0] {
      REG_ROW0 = 3'd0,
      REG_ROW1 = 3'd1,
      REG_ROW2 = 3'd2,
      REG_ROW3 = 3'd3,
      REG_LIMIT = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [47:0] row0;
      logic [47:0] row1;
      logic [47:0] row2;
      logic [47:0] row3;
      logic [14:0] limit;
   } cfg_type;

   function automatic logic signed [34:0] atan_entry(input int i);
      logic signed [34:0] r;
      case (i)
         0: r = 35'sd536870912;
         1: r = 35'sd316933406;
         2: r = 35'sd167458907;
         3: r = 35'sd85004756;
         4: r = 35'sd42667331;
         5: r = 35'sd21354465;
         6: r = 35'sd10679838;
         7: r = 35'sd5340245;
         8: r = 35'sd2670163;
         9: r = 35'sd1335087;
         10: r = 35'sd667544;
         11: r = 35'sd333772;
         12: r = 35'sd166886;
         13: r = 35'sd83443;
         14: r = 35'sd41722;
         15: r = 35'sd20861;
         16: r = 35'sd10430;
         17: r = 35'sd5215;
         18: r = 35'sd2608;
         19: r = 35'sd1304;
         20: r = 35'sd652;
         21: r = 35'sd326;
         22: r = 35'sd163;
         23: r = 35'sd81;
         default: r = 35'sd0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

### hdl/omni_wheel_velocity_mixer.sv
// Omni wheel velocity mixer top level: registers, CORDIC and mixing pipeline.
// Depends on owm_pkg, owm_regs, owm_cordic, owm_mix and the macros header.
//
// Usage: body commands enter on the req_ channel (valid/ready), one beat per
// cycle while req_ready is high. Wheel speeds leave on the rsp_ channel. Jacobian
// rows and the speed limit are to be written over the csr_ APB port (8-byte
// register spacing) only while idle; the block itself does not enforce this.
// Throughput: one beat per cycle unless stalled; the whole path is one
// stall-enabled pipeline. When rsp_ready is low with a result waiting, the
// pipeline freezes and req_ready drops; nothing is lost or repeated. Reset clears
// all valid bits and loads the default registers (zero Jacobian, limit 32767).
`default_nettype none
module omni_wheel_velocity_mixer #(
   parameter int CORDIC_STAGES = owm_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic signed [15:0] req_vel_x,
   input  wire logic signed [15:0] req_vel_y,
   input  wire logic signed [15:0] req_turn_rate,
   input  wire logic [15:0] req_yaw_angle,
   input  wire logic req_field_frame,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic signed [15:0] rsp_wheel_0,
   output logic signed [15:0] rsp_wheel_1,
   output logic signed [15:0] rsp_wheel_2,
   output logic signed [15:0] rsp_wheel_3,
   output logic rsp_limited,
   input  wire logic psel,
   input  wire logic penable,
   input  wire logic pwrite,
   input  wire logic [owm_pkg::ADDR_W-1:0] paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic pready
);
   import owm_pkg::*;
`include "omni_wheel_velocity_mixer_macros.svh"
   cfg_type cfg;
   logic adv, cv;
   logic signed [15:0] cq, sq;
   logic [48:0] sd;
   logic [15:0] w0, w1, w2, w3;

   assign pready = 1'b1;
   assign adv = rsp_ready | ~rsp_valid;
   assign req_ready = adv;

   owm_regs u_regs (
      .clock, .reset, .csr_psel(psel), .csr_penable(penable), .csr_pwrite(pwrite),
      .csr_paddr(paddr), .csr_pwdata(pwdata), .csr_prdata(prdata), .cfg(cfg)
   );

   owm_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(49)) u_cordic (
      .clock, .reset, .adv, .in_valid(req_valid),
      .angle(req_yaw_angle),
      .side_in({req_field_frame, req_turn_rate, req_vel_y, req_vel_x}),
      .out_valid(cv), .cos_q(cq), .sin_q(sq), .side_out(sd)
   );

   owm_mix u_mix (
      .clock, .reset, .adv, .in_valid(cv), .cos_q(cq), .sin_q(sq), .side(sd),
      .cfg(cfg), .out_valid(rsp_valid), .w0(w0), .w1(w1), .w2(w2), .w3(w3),
      .lim_flag(rsp_limited)
   );

   assign rsp_wheel_0 = w0;
   assign rsp_wheel_1 = w1;
   assign rsp_wheel_2 = w2;
   assign rsp_wheel_3 = w3;

   `OWM_ASSERT_NXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_wheel_0))
   `OWM_ASSERT_IMP(a_ready_stall, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `OWM_ASSERT_IMP(a_unlimited_zero, clock, reset,
      rsp_valid && !rsp_limited && cfg.limit == 15'd0, rsp_wheel_0 == 16'sd0)
endmodule
`default_nettype wire

### hdl/owm_regs.sv
// APB register file for the mixer: Jacobian rows and speed limit.
// Depends on owm_pkg.
`default_nettype none
module owm_regs (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [owm_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output owm_pkg::cfg_type cfg
);
   import owm_pkg::*;
   cfg_type cfg_ff;
   logic we;
   logic [2:0] idx;
   assign we = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[ADDR_W-1:3];
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{48'd0, 48'd0, 48'd0, 48'd0, 15'h7fff};
      end else if (we) begin
         case (idx)
            REG_ROW0: cfg_ff.row0 <= csr_pwdata[47:0];
            REG_ROW1: cfg_ff.row1 <= csr_pwdata[47:0];
            REG_ROW2: cfg_ff.row2 <= csr_pwdata[47:0];
            REG_ROW3: cfg_ff.row3 <= csr_pwdata[47:0];
            REG_LIMIT: cfg_ff.limit <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (idx)
         REG_ROW0: csr_prdata = {16'd0, cfg_ff.row0};
         REG_ROW1: csr_prdata = {16'd0, cfg_ff.row1};
         REG_ROW2: csr_prdata = {16'd0, cfg_ff.row2};
         REG_ROW3: csr_prdata = {16'd0, cfg_ff.row3};
         REG_LIMIT: csr_prdata = {49'd0, cfg_ff.limit};
         default: csr_prdata = 64'd0;
      endcase
   end
   assign cfg = cfg_ff;
endmodule
`default_nettype wire

### hdl/owm_cordic.sv
// Unrolled pipelined CORDIC, one stage per register, with side data carried along.
// Depends on owm_pkg.
`default_nettype none
module owm_cordic #(
   parameter int STAGES = owm_pkg::CORDIC_STAGES_DEF,
   parameter int SIDE_W = 49
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic adv,
   input  wire logic in_valid,
   input  wire logic [15:0] angle,
   input  wire logic [SIDE_W-1:0] side_in,
   output logic out_valid,
   output logic signed [15:0] cos_q,
   output logic signed [15:0] sin_q,
   output logic [SIDE_W-1:0] side_out
);
   import owm_pkg::*;
   localparam int N = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;
   logic signed [34:0] x_ff [N+1];
   logic signed [34:0] y_ff [N+1];
   logic signed [34:0] z_ff [N+1];
   logic flip_ff [N+1];
   logic v_ff [N+1];
   logic [SIDE_W-1:0] sd_ff [N+1];
   logic signed [16:0] a_in;
   logic flip_in;
   logic signed [34:0] xr, yr, xs, ys;

   always_comb begin
      flip_in = (angle[15:14] == 2'b01) || (angle[15:14] == 2'b10);
      a_in = flip_in ? ($signed({angle[15], angle}) - (angle[15] ? -17'sd32768 : 17'sd32768))
                     : $signed({angle[15], angle});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= N; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int i = 0; i < N; i++) v_ff[i+1] <= v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0] <= $signed(CORDIC_GAIN);
         y_ff[0] <= 35'sd0;
         z_ff[0] <= 35'(a_in) <<< 16;
         flip_ff[0] <= flip_in;
         sd_ff[0] <= side_in;
         for (int i = 0; i < N; i++) begin
            if (!z_ff[i][34]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_entry(i);
            end
            flip_ff[i+1] <= flip_ff[i];
            sd_ff[i+1] <= sd_ff[i];
         end
      end
   end

   always_comb begin
      xs = flip_ff[N] ? -x_ff[N] : x_ff[N];
      ys = flip_ff[N] ? -y_ff[N] : y_ff[N];
      xr = (xs + 35'sd32768) >>> 16;
      yr = (ys + 35'sd32768) >>> 16;
   end
   assign cos_q = xr[15:0];
   assign sin_q = yr[15:0];
   assign out_valid = v_ff[N];
   assign side_out = sd_ff[N];
endmodule
`default_nettype wire

### hdl/owm_mix.sv
// Rotation, Jacobian mixing and limit rescale pipeline.
// Depends on owm_pkg.
`default_nettype none
module owm_mix (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic adv,
   input  wire logic in_valid,
   input  wire logic signed [15:0] cos_q,
   input  wire logic signed [15:0] sin_q,
   input  wire logic [48:0] side,
   input  wire owm_pkg::cfg_type cfg,
   output logic out_valid,
   output logic [15:0] w0,
   output logic [15:0] w1,
   output logic [15:0] w2,
   output logic [15:0] w3,
   output logic lim_flag
);
   import owm_pkg::*;
   // stage 1: rotation products
   logic v1_ff, ff1_ff;
   logic signed [31:0] p_cx_ff, p_sy_ff, p_cy_ff, p_sx_ff;
   logic signed [15:0] vx1_ff, vy1_ff, vw1_ff;
   // stage 2: rotated vector
   logic v2_ff;
   logic signed [18:0] rx_ff, ry_ff;
   logic signed [15:0] vw2_ff;
   // stage 3: mix products
   logic v3_ff;
   logic signed [34:0] pm_ff [4][3];
   // stage 4: wheel speeds
   logic v4_ff;
   logic signed [25:0] w4_ff [4];
   // stage 5: magnitudes
   logic v5_ff;
   logic [25:0] a5_ff [4];
   logic s5_ff [4];
   // divider stages: |w| * limit / max by long division
   localparam int QB = 41;
   localparam int DS = 6;
   localparam int BPS = 7;
   logic dv_ff [DS+1];
   logic [40:0] dn_ff [DS+1][4];
   logic [40:0] dq_ff [DS+1][4];
   logic [41:0] dr_ff [DS+1][4];
   logic [25:0] dm_ff [DS+1];
   logic ds_ff [DS+1][4];
   logic [25:0] da_ff [DS+1][4];
   logic dl_ff [DS+1];
   // output
   logic vo_ff;
   logic [15:0] wo_ff [4];
   logic lo_ff;

   logic signed [47:0] rows [4];
   logic signed [18:0] rx_in, ry_in;
   logic signed [35:0] sum4 [4];
   logic [25:0] mx;
   logic [14:0] lim;

   assign rows[0] = cfg.row0;
   assign rows[1] = cfg.row1;
   assign rows[2] = cfg.row2;
   assign rows[3] = cfg.row3;
   assign lim = cfg.limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; vo_ff <= 1'b0;
         for (int i = 0; i <= DS; i++) dv_ff[i] <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; dv_ff[0] <= v5_ff;
         for (int i = 0; i < DS; i++) dv_ff[i+1] <= dv_ff[i];
         vo_ff <= dv_ff[DS];
      end
   end

   always_comb begin
      rx_in = 19'((33'(p_cx_ff) + 33'(p_sy_ff) + 33'sd8192) >>> 14);
      ry_in = 19'((33'(p_cy_ff) - 33'(p_sx_ff) + 33'sd8192) >>> 14);
      for (int k = 0; k < 4; k++)
         sum4[k] = 36'(pm_ff[k][0]) + 36'(pm_ff[k][1]) + 36'(pm_ff[k][2]) + 36'sd2048;
      mx = a5_ff[0];
      for (int k = 1; k < 4; k++) if (a5_ff[k] > mx) mx = a5_ff[k];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ff1_ff <= side[48];
         vx1_ff <= side[15:0]; vy1_ff <= side[31:16]; vw1_ff <= side[47:32];
         p_cx_ff <= cos_q * $signed(side[15:0]);
         p_sy_ff <= sin_q * $signed(side[31:16]);
         p_cy_ff <= cos_q * $signed(side[31:16]);
         p_sx_ff <= sin_q * $signed(side[15:0]);
         rx_ff <= ff1_ff ? rx_in : 19'(vx1_ff);
         ry_ff <= ff1_ff ? ry_in : 19'(vy1_ff);
         vw2_ff <= vw1_ff;
         for (int k = 0; k < 4; k++) begin
            pm_ff[k][0] <= 35'($signed(rows[k][15:0]) * rx_ff);
            pm_ff[k][1] <= 35'($signed(rows[k][31:16]) * ry_ff);
            pm_ff[k][2] <= 35'($signed(rows[k][47:32]) * vw2_ff);
            w4_ff[k] <= 26'(sum4[k] >>> 12);
            s5_ff[k] <= w4_ff[k][25];
            a5_ff[k] <= w4_ff[k][25] ? 26'(-w4_ff[k]) : 26'(w4_ff[k]);
         end
         dm_ff[0] <= mx;
         dl_ff[0] <= (mx > 26'(lim));
         for (int k = 0; k < 4; k++) begin
            dn_ff[0][k] <= 41'(a5_ff[k]) * 41'(lim);
            dq_ff[0][k] <= 41'd0;
            dr_ff[0][k] <= 42'd0;
            ds_ff[0][k] <= s5_ff[k];
            da_ff[0][k] <= a5_ff[k];
         end
         for (int i = 0; i < DS; i++) begin : dstage
            logic [40:0] nq, nn;
            logic [41:0] nr;
            dm_ff[i+1] <= dm_ff[i];
            dl_ff[i+1] <= dl_ff[i];
            for (int k = 0; k < 4; k++) begin
               nq = dq_ff[i][k]; nn = dn_ff[i][k]; nr = dr_ff[i][k];
               for (int b = 0; b < BPS; b++) begin
                  if (i * BPS + b < QB) begin
                     nr = {nr[40:0], nn[40]};
                     nn = {nn[39:0], 1'b0};
                     if (nr >= 42'(dm_ff[i])) begin
                        nr = nr - 42'(dm_ff[i]);
                        nq = {nq[39:0], 1'b1};
                     end else begin
                        nq = {nq[39:0], 1'b0};
                     end
                  end
               end
               dq_ff[i+1][k] <= nq; dn_ff[i+1][k] <= nn; dr_ff[i+1][k] <= nr;
               ds_ff[i+1][k] <= ds_ff[i][k];
               da_ff[i+1][k] <= da_ff[i][k];
            end
         end
         lo_ff <= dl_ff[DS];
         for (int k = 0; k < 4; k++) begin
            if (dl_ff[DS]) begin
               if (dq_ff[DS][k] > 41'(lim))
                  wo_ff[k] <= ds_ff[DS][k] ? -16'(lim) : 16'(lim);
               else
                  wo_ff[k] <= ds_ff[DS][k] ? -dq_ff[DS][k][15:0] : dq_ff[DS][k][15:0];
            end else begin
               wo_ff[k] <= ds_ff[DS][k] ? -da_ff[DS][k][15:0] : da_ff[DS][k][15:0];
            end
         end
      end
   end

   assign out_valid = vo_ff;
   assign w0 = wo_ff[0];
   assign w1 = wo_ff[1];
   assign w2 = wo_ff[2];
   assign w3 = wo_ff[3];
   assign lim_flag = lo_ff;
endmodule
`default_nettype wire

### tb/sv/omni_wheel_velocity_mixer_test.sv
// Testbench for omni_wheel_velocity_mixer: a directed table of commands, then random
// commands under several Jacobian and limit settings, checked against a local predictor.
// Depends on owm_pkg and the mixer RTL.
`timescale 1ns / 1ps
`default_nettype none
module omni_wheel_velocity_mixer_test;
   import owm_pkg::*;

   localparam int STAGES = 16;
   localparam int LATENCY = STAGES + 14;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM = 850;

   typedef struct {
      logic signed [15:0] vx, vy, vw;
      logic [15:0] yaw;
      logic ff;
   } command_type;

   typedef struct {
      logic signed [15:0] w [4];
      logic lim;
   } wheels_type;

   typedef struct {
      command_type cmd;
      logic known;
      wheels_type exp;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [15:0] req_vel_x = 0, req_vel_y = 0, req_turn_rate = 0;
   logic [15:0] req_yaw_angle = 0;
   logic req_field_frame = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [15:0] rsp_wheel_0, rsp_wheel_1, rsp_wheel_2, rsp_wheel_3;
   logic rsp_limited;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [ADDR_W-1:0] paddr = 0;
   logic [63:0] pwdata = 0;
   logic [63:0] prdata;
   logic pready;

   omni_wheel_velocity_mixer #(.CORDIC_STAGES(STAGES)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y), .req_turn_rate(req_turn_rate),
      .req_yaw_angle(req_yaw_angle), .req_field_frame(req_field_frame),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_wheel_0(rsp_wheel_0), .rsp_wheel_1(rsp_wheel_1),
      .rsp_wheel_2(rsp_wheel_2), .rsp_wheel_3(rsp_wheel_3),
      .rsp_limited(rsp_limited),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   logic [47:0] jac [4];
   logic [14:0] speed_limit;
   wheels_type pending_wheels [$];
   int errors = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit calm = 0;

   function automatic longint floor_div2(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_div2(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic void heading_cos_sin(logic [15:0] yaw, output longint c,
         output longint s);
      longint a, x, y, z, dx, dy;
      bit flip;
      a = longint'($signed(yaw));
      x = 652032874;
      y = 0;
      flip = 0;
      if (a >= 16384 || a < -16384) begin
         flip = 1;
         a = (a > 0) ? a - 32768 : a + 32768;
      end
      z = a * 65536;
      for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
         dx = floor_div2(y, i);
         dy = floor_div2(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_entry(i));
         end else begin
            x += dx; y -= dy; z += longint'(atan_entry(i));
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = round_div2(x, 16);
      s = round_div2(y, 16);
   endfunction

   function automatic wheels_type mix_wheels(command_type cmd);
      wheels_type r;
      longint rx, ry, c, s, acc, m, a, q, lim;
      longint w [4];
      rx = cmd.vx;
      ry = cmd.vy;
      if (cmd.ff) begin
         heading_cos_sin(cmd.yaw, c, s);
         rx = round_div2(c * cmd.vx + s * cmd.vy, 14);
         ry = round_div2(c * cmd.vy - s * cmd.vx, 14);
      end
      m = 0;
      lim = speed_limit;
      for (int k = 0; k < 4; k++) begin
         acc = longint'($signed(jac[k][15:0])) * rx
             + longint'($signed(jac[k][31:16])) * ry
             + longint'($signed(jac[k][47:32])) * cmd.vw;
         w[k] = round_div2(acc, 12);
         a = w[k] < 0 ? -w[k] : w[k];
         if (a > m) m = a;
      end
      r.lim = m > lim;
      for (int k = 0; k < 4; k++) begin
         if (r.lim) begin
            a = w[k] < 0 ? -w[k] : w[k];
            q = (a * lim) / m;
            if (q > lim) q = lim;
            w[k] = w[k] < 0 ? -q : q;
         end
         r.w[k] = w[k][15:0];
      end
      return r;
   endfunction

   task automatic write_reg(reg_index_type idx, logic [63:0] value);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= ADDR_W'(8 * idx); pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (idx)
         REG_LIMIT: speed_limit = value[14:0];
         default: jac[idx] = value[47:0];
      endcase
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending_wheels.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic send(command_type cmd, logic known, wheels_type typed);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_vel_x <= cmd.vx; req_vel_y <= cmd.vy; req_turn_rate <= cmd.vw;
      req_yaw_angle <= cmd.yaw; req_field_frame <= cmd.ff;
      pending_wheels.push_back(known ? typed : mix_wheels(cmd));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_q16();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(0, 1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [47:0] rand_row();
      logic [47:0] r;
      for (int j = 0; j < 3; j++)
         r[16*j +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
            : 16'($signed($urandom_range(0, 8192)) - 4096);
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            rsp_ready <= 0;
            stall_left <= stall_left - 1;
         end else if (!rsp_ready || calm || $urandom_range(0, 7) != 0) begin
            rsp_ready <= 1;
         end else begin
            rsp_ready <= 0;
            stall_left <= $urandom_range(0, 13);
         end
      end
   end

   always @(posedge clock) begin
      wheels_type e;
      logic signed [15:0] got [4];
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || pending_wheels.size() == 0)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_wheels.size() == 0) begin
               $error("unexpected beat on rsp channel");
               errors++;
            end else begin
               e = pending_wheels.pop_front();
               got[0] = rsp_wheel_0; got[1] = rsp_wheel_1;
               got[2] = rsp_wheel_2; got[3] = rsp_wheel_3;
               for (int k = 0; k < 4; k++)
                  if (got[k] !== e.w[k]) begin
                     $error("wheel_%0d expected %0d got %0d", k, e.w[k], got[k]);
                     errors++;
                  end
               if (rsp_limited !== e.lim) begin
                  $error("limited expected %0d got %0d", e.lim, rsp_limited);
                  errors++;
               end
            end
         end
      end
   end

   row_type dir_rows [$];

   initial begin
      command_type cmd;
      wheels_type typed;
      row_type row;
      for (int k = 0; k < 4; k++) jac[k] = 0;
      speed_limit = 15'h7fff;
      repeat (8) @(posedge clock);
      reset <= 0;

      // zero Jacobian after reset: all zero, never limited
      cmd = '{16'h7fff, 16'h8000, 16'h8000, 16'hffff, 1'b1};
      typed.w = '{0, 0, 0, 0}; typed.lim = 0;
      send(cmd, 1, typed);
      drain();

      // identity-like rows: wheels 0, 1, 2 pick x, y, turn; wheel 3 takes minus their sum
      write_reg(REG_ROW0, 48'h0000_0000_1000);
      write_reg(REG_ROW1, 48'h0000_1000_0000);
      write_reg(REG_ROW2, 48'h1000_0000_0000);
      write_reg(REG_ROW3, 48'hf000_f000_f000);
      write_reg(REG_LIMIT, 64'h7fff);
      begin
         logic [15:0] yaws [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
                                   16'h3fff, 16'hbfff, 16'h7fff, 16'hffff};
         row.known = 0;
         row.exp = typed;
         for (int i = 0; i < 8; i++) begin
            row.cmd = '{16'h0100, 16'h0080, 16'h0040, yaws[i], 1'b1};
            dir_rows.push_back(row);
         end
         row.cmd = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h1234, 1'b0}; dir_rows.push_back(row);
         row.cmd = '{16'h8000, 16'h8000, 16'h8000, 16'hedcb, 1'b0}; dir_rows.push_back(row);
         row.cmd = '{16'h8000, 16'h7fff, 16'h0000, 16'h2000, 1'b1}; dir_rows.push_back(row);
         row.cmd = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0}; dir_rows.push_back(row);
      end
      foreach (dir_rows[i]) send(dir_rows[i].cmd, dir_rows[i].known, dir_rows[i].exp);
      drain();

      // zero limit: anything nonzero rescales to zero
      write_reg(REG_LIMIT, 64'h0);
      cmd = '{16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0};
      typed.w = '{0, 0, 0, 0}; typed.lim = 1;
      send(cmd, 1, typed);
      cmd = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0};
      typed.lim = 0;
      send(cmd, 1, typed);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         for (int k = 0; k < 4; k++) write_reg(reg_index_type'(k), rand_row());
         case (phase)
            0: write_reg(REG_LIMIT, 64'h7fff);
            1: write_reg(REG_LIMIT, 64'h0);
            2: write_reg(REG_LIMIT, 64'h1);
            default: write_reg(REG_LIMIT, 64'($urandom_range(0, 32767)));
         endcase
         calm = (phase == 4);
         for (int i = 0; i < N_RANDOM / 5; i++) begin
            cmd.vx = rand_q16(); cmd.vy = rand_q16(); cmd.vw = rand_q16();
            cmd.yaw = 16'($urandom); cmd.ff = $urandom_range(0, 1);
            send(cmd, 0, typed);
         end
         drain();
      end

      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire
